// ===== rtl/hpk_pkg.sv =====
`timescale 1ns / 1ps

package hpk_pkg;

  localparam int COUNT_BITS = 16;
  localparam int CODE_W     = 30;
  localparam int LEN_W      = 5;
  localparam int WORD_W     = 40;
  localparam int FIFO_DEPTH = 2;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last_symbol;
  } hpk_in_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        last_byte;
    logic [15:0] byte_count;
    logic        overflow;
  } hpk_out_t;

  // Bits to send, left aligned, with the number of whole bytes they fill.
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [2:0]        nbytes;
    logic              last;
  } hpk_job_t;

  localparam logic [CODE_W-1:0] CODE_ROM [0:255] = '{
    30'h1ff8, 30'h7fffd8, 30'hfffffe2, 30'hfffffe3,
    30'hfffffe4, 30'hfffffe5, 30'hfffffe6, 30'hfffffe7,
    30'hfffffe8, 30'hffffea, 30'h3ffffffc, 30'hfffffe9,
    30'hfffffea, 30'h3ffffffd, 30'hfffffeb, 30'hfffffec,
    30'hfffffed, 30'hfffffee, 30'hfffffef, 30'hffffff0,
    30'hffffff1, 30'hffffff2, 30'h3ffffffe, 30'hffffff3,
    30'hffffff4, 30'hffffff5, 30'hffffff6, 30'hffffff7,
    30'hffffff8, 30'hffffff9, 30'hffffffa, 30'hffffffb,
    30'h14, 30'h3f8, 30'h3f9, 30'hffa, 30'h1ff9, 30'h15, 30'hf8, 30'h7fa,
    30'h3fa, 30'h3fb, 30'hf9, 30'h7fb, 30'hfa, 30'h16, 30'h17, 30'h18,
    30'h0, 30'h1, 30'h2, 30'h19, 30'h1a, 30'h1b, 30'h1c, 30'h1d,
    30'h1e, 30'h1f, 30'h5c, 30'hfb, 30'h7ffc, 30'h20, 30'hffb, 30'h3fc,
    30'h1ffa, 30'h21, 30'h5d, 30'h5e, 30'h5f, 30'h60, 30'h61, 30'h62,
    30'h63, 30'h64, 30'h65, 30'h66, 30'h67, 30'h68, 30'h69, 30'h6a,
    30'h6b, 30'h6c, 30'h6d, 30'h6e, 30'h6f, 30'h70, 30'h71, 30'h72,
    30'hfc, 30'h73, 30'hfd, 30'h1ffb, 30'h7fff0, 30'h1ffc, 30'h3ffc, 30'h22,
    30'h7ffd, 30'h3, 30'h23, 30'h4, 30'h24, 30'h5, 30'h25, 30'h26,
    30'h27, 30'h6, 30'h74, 30'h75, 30'h28, 30'h29, 30'h2a, 30'h7,
    30'h2b, 30'h76, 30'h2c, 30'h8, 30'h9, 30'h2d, 30'h77, 30'h78,
    30'h79, 30'h7a, 30'h7b, 30'h7ffe, 30'h7fc, 30'h3ffd, 30'h1ffd, 30'hffffffc,
    30'hfffe6, 30'h3fffd2, 30'hfffe7, 30'hfffe8,
    30'h3fffd3, 30'h3fffd4, 30'h3fffd5, 30'h7fffd9,
    30'h3fffd6, 30'h7fffda, 30'h7fffdb, 30'h7fffdc,
    30'h7fffdd, 30'h7fffde, 30'hffffeb, 30'h7fffdf,
    30'hffffec, 30'hffffed, 30'h3fffd7, 30'h7fffe0,
    30'hffffee, 30'h7fffe1, 30'h7fffe2, 30'h7fffe3,
    30'h7fffe4, 30'h1fffdc, 30'h3fffd8, 30'h7fffe5,
    30'h3fffd9, 30'h7fffe6, 30'h7fffe7, 30'hffffef,
    30'h3fffda, 30'h1fffdd, 30'hfffe9, 30'h3fffdb,
    30'h3fffdc, 30'h7fffe8, 30'h7fffe9, 30'h1fffde,
    30'h7fffea, 30'h3fffdd, 30'h3fffde, 30'hfffff0,
    30'h1fffdf, 30'h3fffdf, 30'h7fffeb, 30'h7fffec,
    30'h1fffe0, 30'h1fffe1, 30'h3fffe0, 30'h1fffe2,
    30'h7fffed, 30'h3fffe1, 30'h7fffee, 30'h7fffef,
    30'hfffea, 30'h3fffe2, 30'h3fffe3, 30'h3fffe4,
    30'h7ffff0, 30'h3fffe5, 30'h3fffe6, 30'h7ffff1,
    30'h3ffffe0, 30'h3ffffe1, 30'hfffeb, 30'h7fff1,
    30'h3fffe7, 30'h7ffff2, 30'h3fffe8, 30'h1ffffec,
    30'h3ffffe2, 30'h3ffffe3, 30'h3ffffe4, 30'h7ffffde,
    30'h7ffffdf, 30'h3ffffe5, 30'hfffff1, 30'h1ffffed,
    30'h7fff2, 30'h1fffe3, 30'h3ffffe6, 30'h7ffffe0,
    30'h7ffffe1, 30'h3ffffe7, 30'h7ffffe2, 30'hfffff2,
    30'h1fffe4, 30'h1fffe5, 30'h3ffffe8, 30'h3ffffe9,
    30'hffffffd, 30'h7ffffe3, 30'h7ffffe4, 30'h7ffffe5,
    30'hfffec, 30'hfffff3, 30'hfffed, 30'h1fffe6,
    30'h3fffe9, 30'h1fffe7, 30'h1fffe8, 30'h7ffff3,
    30'h3fffea, 30'h3fffeb, 30'h1ffffee, 30'h1ffffef,
    30'hfffff4, 30'hfffff5, 30'h3ffffea, 30'h7ffff4,
    30'h3ffffeb, 30'h7ffffe6, 30'h3ffffec, 30'h3ffffed,
    30'h7ffffe7, 30'h7ffffe8, 30'h7ffffe9, 30'h7ffffea,
    30'h7ffffeb, 30'hffffffe, 30'h7ffffec, 30'h7ffffed,
    30'h7ffffee, 30'h7ffffef, 30'h7fffff0, 30'h3ffffee
  };

  localparam logic [LEN_W-1:0] LEN_ROM [0:255] = '{
    5'd13, 5'd23, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28,
    5'd28, 5'd24, 5'd30, 5'd28, 5'd28, 5'd30, 5'd28, 5'd28,
    5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd30, 5'd28,
    5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28,
    5'd6, 5'd10, 5'd10, 5'd12, 5'd13, 5'd6, 5'd8, 5'd11,
    5'd10, 5'd10, 5'd8, 5'd11, 5'd8, 5'd6, 5'd6, 5'd6,
    5'd5, 5'd5, 5'd5, 5'd6, 5'd6, 5'd6, 5'd6, 5'd6,
    5'd6, 5'd6, 5'd7, 5'd8, 5'd15, 5'd6, 5'd12, 5'd10,
    5'd13, 5'd6, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7,
    5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7,
    5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7,
    5'd8, 5'd7, 5'd8, 5'd13, 5'd19, 5'd13, 5'd14, 5'd6,
    5'd15, 5'd5, 5'd6, 5'd5, 5'd6, 5'd5, 5'd6, 5'd6,
    5'd6, 5'd5, 5'd7, 5'd7, 5'd6, 5'd6, 5'd6, 5'd5,
    5'd6, 5'd7, 5'd6, 5'd5, 5'd5, 5'd6, 5'd7, 5'd7,
    5'd7, 5'd7, 5'd7, 5'd15, 5'd11, 5'd14, 5'd13, 5'd28,
    5'd20, 5'd22, 5'd20, 5'd20, 5'd22, 5'd22, 5'd22, 5'd23,
    5'd22, 5'd23, 5'd23, 5'd23, 5'd23, 5'd23, 5'd24, 5'd23,
    5'd24, 5'd24, 5'd22, 5'd23, 5'd24, 5'd23, 5'd23, 5'd23,
    5'd23, 5'd21, 5'd22, 5'd23, 5'd22, 5'd23, 5'd23, 5'd24,
    5'd22, 5'd21, 5'd20, 5'd22, 5'd22, 5'd23, 5'd23, 5'd21,
    5'd23, 5'd22, 5'd22, 5'd24, 5'd21, 5'd22, 5'd23, 5'd23,
    5'd21, 5'd21, 5'd22, 5'd21, 5'd23, 5'd22, 5'd23, 5'd23,
    5'd20, 5'd22, 5'd22, 5'd22, 5'd23, 5'd22, 5'd22, 5'd23,
    5'd26, 5'd26, 5'd20, 5'd19, 5'd22, 5'd23, 5'd22, 5'd25,
    5'd26, 5'd26, 5'd26, 5'd27, 5'd27, 5'd26, 5'd24, 5'd25,
    5'd19, 5'd21, 5'd26, 5'd27, 5'd27, 5'd26, 5'd27, 5'd24,
    5'd21, 5'd21, 5'd26, 5'd26, 5'd28, 5'd27, 5'd27, 5'd27,
    5'd20, 5'd24, 5'd20, 5'd21, 5'd22, 5'd21, 5'd21, 5'd23,
    5'd22, 5'd22, 5'd25, 5'd25, 5'd24, 5'd24, 5'd26, 5'd23,
    5'd26, 5'd27, 5'd26, 5'd26, 5'd27, 5'd27, 5'd27, 5'd27,
    5'd27, 5'd28, 5'd27, 5'd27, 5'd27, 5'd27, 5'd27, 5'd26
  };

endpackage

// ===== rtl/hpk_front.sv =====
`timescale 1ns / 1ps

module hpk_front import hpk_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  hpk_in_t  in_data,
  input  logic     job_ready,
  output logic     job_push,
  output hpk_job_t job
);

  logic [7:0]        partial_r, partial_nxt;
  logic [2:0]        pend_r, pend_nxt;
  logic              accept;
  logic [CODE_W-1:0] code;
  logic [LEN_W-1:0]  len;
  logic [CODE_W-1:0] code_left;
  logic [WORD_W-1:0] word;
  logic [WORD_W-1:0] shifted;
  logic [5:0]        nbits;
  logic [2:0]        full;

  assign in_ready = job_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    code      = CODE_ROM[in_data.symbol];
    len       = LEN_ROM[in_data.symbol];
    code_left = code << (5'(CODE_W) - len);
    word      = {partial_r, 32'b0} | ({code_left, 10'b0} >> pend_r);
    nbits     = {3'b000, pend_r} + {1'b0, len};
    full      = nbits[5:3];
    shifted   = word << {full, 3'b000};

    job.last = in_data.last_symbol;
    if (in_data.last_symbol) begin
      job.word   = word | ({WORD_W{1'b1}} >> nbits);
      job.nbytes = full + {2'b00, (nbits[2:0] != 3'd0)};
    end else begin
      job.word   = word;
      job.nbytes = full;
    end
    job_push = accept && (job.nbytes != 3'd0);

    partial_nxt = partial_r;
    pend_nxt    = pend_r;
    if (accept) begin
      if (in_data.last_symbol) begin
        partial_nxt = 8'h00;
        pend_nxt    = 3'd0;
      end else begin
        partial_nxt = shifted[WORD_W-1 -: 8];
        pend_nxt    = nbits[2:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= 8'h00;
      pend_r    <= 3'd0;
    end else begin
      partial_r <= partial_nxt;
      pend_r    <= pend_nxt;
    end
  end

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.last_symbol) |=> (pend_r == 3'd0 && partial_r == 8'h00))
    else $error("front state not cleared after last symbol");

endmodule

// ===== rtl/hpk_job_fifo.sv =====
`timescale 1ns / 1ps

module hpk_job_fifo import hpk_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  hpk_job_t push_data,
  output logic     not_full,
  input  logic     pop,
  output logic     not_empty,
  output hpk_job_t pop_data
);

  hpk_job_t   mem [FIFO_DEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign not_full  = (count_r != 2'(FIFO_DEPTH));
  assign not_empty = (count_r != 2'd0);
  assign pop_data  = mem[rd_ptr_r];
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_lost_push: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> not_full)
    else $error("job pushed into a full queue");

endmodule

// ===== rtl/hpk_back.sv =====
`timescale 1ns / 1ps

module hpk_back import hpk_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        job_valid,
  input  hpk_job_t    job,
  output logic        job_pop,
  input  logic [15:0] capacity,
  output logic        out_valid,
  input  logic        out_ready,
  output hpk_out_t    out_data
);

  logic                  busy_r, busy_nxt;
  logic [WORD_W-1:0]     word_r, word_nxt;
  logic [2:0]            left_r, left_nxt;
  logic                  last_r, last_nxt;
  logic [COUNT_BITS-1:0] emitted_r, emitted_nxt;
  logic                  ovf_r, ovf_nxt;
  logic                  out_valid_r, out_valid_nxt;
  hpk_out_t              out_r, out_nxt;
  logic                  advance, emit, finishing, is_last, drop;
  logic [COUNT_BITS-1:0] count_after;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    advance   = !out_valid_r || out_ready;
    emit      = busy_r && advance;
    finishing = emit && (left_r == 3'd1);
    job_pop   = job_valid && (!busy_r || finishing);
    is_last   = last_r && (left_r == 3'd1);
    drop      = ovf_r || (32'(emitted_r) >= 32'(capacity)) || (emitted_r == '1);
    count_after = drop ? emitted_r : emitted_r + COUNT_BITS'(1);

    busy_nxt      = busy_r;
    word_nxt      = word_r;
    left_nxt      = left_r;
    last_nxt      = last_r;
    emitted_nxt   = emitted_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;

    if (job_pop) begin
      busy_nxt = 1'b1;
      word_nxt = job.word;
      left_nxt = job.nbytes;
      last_nxt = job.last;
    end else if (finishing) begin
      busy_nxt = 1'b0;
    end else if (emit) begin
      word_nxt = word_r << 8;
      left_nxt = left_r - 3'd1;
    end

    if (emit) begin
      out_valid_nxt      = 1'b1;
      out_nxt.out_byte   = drop ? 8'h00 : word_r[WORD_W-1 -: 8];
      out_nxt.last_byte  = is_last;
      out_nxt.byte_count = 16'(count_after);
      out_nxt.overflow   = drop;
      if (is_last) begin
        emitted_nxt = '0;
        ovf_nxt     = 1'b0;
      end else begin
        emitted_nxt = count_after;
        ovf_nxt     = drop;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    left_r <= left_nxt;
    last_r <= last_nxt;
    out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      emitted_r   <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      emitted_r   <= emitted_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_string_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && is_last) |=> (emitted_r == '0 && !ovf_r))
    else $error("byte count not cleared at end of string");

  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && drop) |=> (out_r.overflow && out_r.out_byte == 8'h00))
    else $error("dropped byte carries data");

  a_busy_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (left_r != 3'd0))
    else $error("active job with no bytes left");

endmodule

// ===== rtl/hpack_huffman_bit_packer_unit.sv =====
`timescale 1ns / 1ps

// HPACK Huffman bit packer.
// The input channel (in_valid, in_ready, in_data) takes one string byte per
// request, with last_symbol set on the final byte of the string. The byte's
// Huffman code is packed MSB first; the result channel (out_valid, out_ready,
// out_data) returns one packed byte per request, from zero to five per input.
// On the last symbol the tail is padded with ones and the final byte carries
// last_byte and the total byte count. Bytes beyond the capacity register come
// out with overflow set and a zero data byte. The cfg channel writes the
// capacity and is always ready; write it only while the block is idle.
// The first byte of an input passes through the job queue, the job register of
// the serializer and the output register before it is presented. The output
// serializer sends one byte per cycle while the receiver is ready, at most five
// per input. A two-entry job queue sits between the code lookup and the
// serializer, so inputs keep being accepted while the receiver stalls until the
// queue fills. Reset clears the string state and sets the capacity to 65535.

module hpack_huffman_bit_packer_unit import hpk_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  hpk_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output hpk_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic [15:0] capacity_r, capacity_nxt;
  logic        job_push, job_ready, job_valid, job_pop;
  hpk_job_t    push_job, pop_job;

  assign cfg_ready    = 1'b1;
  assign capacity_nxt = (cfg_valid && cfg_ready) ? cfg_data : capacity_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= 16'hffff;
    end else begin
      capacity_r <= capacity_nxt;
    end
  end

  hpk_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .job_ready (job_ready),
    .job_push  (job_push),
    .job       (push_job)
  );

  hpk_job_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (push_job),
    .not_full  (job_ready),
    .pop       (job_pop),
    .not_empty (job_valid),
    .pop_data  (pop_job)
  );

  hpk_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job       (pop_job),
    .job_pop   (job_pop),
    .capacity  (capacity_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

import hpk_pkg::*;

class huffman_pack_model;
  bit [4:0]          code_len [256];
  bit [29:0]         code_word [256];
  int unsigned       capacity;
  bit [7:0]          partial_byte;
  int unsigned       held_bits;
  longint unsigned   emitted;
  longint unsigned   count_max;
  bit                dropping;
  hpk_out_t          pending_bytes [$];
  int                mismatch_count;

  // The code table is canonical, so the code words follow from the lengths.
  function new();
    int l;
    int s;
    bit [31:0] next_code;
    code_len = '{
      13, 23, 28, 28, 28, 28, 28, 28, 28, 24, 30, 28, 28, 30, 28, 28,
      28, 28, 28, 28, 28, 28, 30, 28, 28, 28, 28, 28, 28, 28, 28, 28,
      6, 10, 10, 12, 13, 6, 8, 11, 10, 10, 8, 11, 8, 6, 6, 6,
      5, 5, 5, 6, 6, 6, 6, 6, 6, 6, 7, 8, 15, 6, 12, 10,
      13, 6, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7,
      7, 7, 7, 7, 7, 7, 7, 7, 8, 7, 8, 13, 19, 13, 14, 6,
      15, 5, 6, 5, 6, 5, 6, 6, 6, 5, 7, 7, 6, 6, 6, 5,
      6, 7, 6, 5, 5, 6, 7, 7, 7, 7, 7, 15, 11, 14, 13, 28,
      20, 22, 20, 20, 22, 22, 22, 23, 22, 23, 23, 23, 23, 23, 24, 23,
      24, 24, 22, 23, 24, 23, 23, 23, 23, 21, 22, 23, 22, 23, 23, 24,
      22, 21, 20, 22, 22, 23, 23, 21, 23, 22, 22, 24, 21, 22, 23, 23,
      21, 21, 22, 21, 23, 22, 23, 23, 20, 22, 22, 22, 23, 22, 22, 23,
      26, 26, 20, 19, 22, 23, 22, 25, 26, 26, 26, 27, 27, 26, 24, 25,
      19, 21, 26, 27, 27, 26, 27, 24, 21, 21, 26, 26, 28, 27, 27, 27,
      20, 24, 20, 21, 22, 21, 21, 23, 22, 22, 25, 25, 24, 24, 26, 23,
      26, 27, 26, 26, 27, 27, 27, 27, 27, 28, 27, 27, 27, 27, 27, 26
    };
    next_code = 0;
    for (l = 1; l <= 30; l++) begin
      for (s = 0; s < 256; s++) begin
        if (code_len[s] == l) begin
          code_word[s] = next_code[29:0];
          next_code++;
        end
      end
      next_code = next_code << 1;
    end
    count_max = (64'd1 << COUNT_BITS) - 1;
    capacity = 65535;
    partial_byte = 0;
    held_bits = 0;
    emitted = 0;
    dropping = 0;
    mismatch_count = 0;
  endfunction

  function void emit_byte(bit [7:0] value, bit is_last);
    hpk_out_t r;
    if (dropping || emitted >= capacity || emitted >= count_max) begin
      dropping = 1'b1;
      r.out_byte = 8'h00;
      r.overflow = 1'b1;
    end else begin
      emitted = (emitted + 1) & count_max;
      r.out_byte = value;
      r.overflow = 1'b0;
    end
    r.last_byte = is_last;
    r.byte_count = 16'(emitted);
    pending_bytes.push_back(r);
  endfunction

  function void encode_symbol(hpk_in_t req);
    bit [63:0] acc;
    int unsigned len;
    int unsigned nbits;
    bit [31:0] rem;
    len = code_len[req.symbol];
    acc = 64'(partial_byte) >> (8 - held_bits);
    acc = (acc << len) | 64'(code_word[req.symbol]);
    nbits = held_bits + len;
    while (nbits >= 8) begin
      nbits -= 8;
      emit_byte(8'(acc >> nbits), req.last_symbol && nbits == 0);
    end
    rem = 32'(acc & ((64'd1 << nbits) - 1));
    if (req.last_symbol) begin
      if (nbits > 0) begin
        emit_byte(8'((rem << (8 - nbits)) | ((32'd1 << (8 - nbits)) - 1)), 1'b1);
      end
      partial_byte = 0;
      held_bits = 0;
      emitted = 0;
      dropping = 0;
    end else begin
      partial_byte = 8'(rem << (8 - nbits));
      held_bits = nbits;
    end
  endfunction

  function void check_byte(hpk_out_t got);
    hpk_out_t want;
    if (pending_bytes.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("%0t: unexpected result byte=%02h last=%0d count=%0d ovf=%0d", $time,
                 got.out_byte, got.last_byte, got.byte_count, got.overflow);
      end
      return;
    end
    want = pending_bytes.pop_front();
    if (got.out_byte !== want.out_byte || got.last_byte !== want.last_byte ||
        got.byte_count !== want.byte_count || got.overflow !== want.overflow) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("%0t: mismatch expected byte=%02h last=%0d count=%0d ovf=%0d", $time,
                 want.out_byte, want.last_byte, want.byte_count, want.overflow);
        $display("%0t:          actual   byte=%02h last=%0d count=%0d ovf=%0d", $time,
                 got.out_byte, got.last_byte, got.byte_count, got.overflow);
      end
    end
  endfunction
endclass

module tb;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 16;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  hpk_in_t     in_data;
  logic        out_valid;
  logic        out_ready;
  hpk_out_t    out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  huffman_pack_model model;
  bit          in_gaps_on;
  bit          out_gaps_on;
  int          sent_count;
  int unsigned quiet_cycles;

  hpack_huffman_bit_packer_unit uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic bit [15:0] pick_capacity();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'hffff;
      2: return 16'($urandom_range(1, 3));
      3: return 16'($urandom_range(4, 24));
      4: return 16'($urandom_range(0, 65535));
      default: return 16'hffff;
    endcase
  endfunction

  task automatic send_symbol(bit [7:0] sym, bit last_flag);
    hpk_in_t req;
    int gap;
    req.symbol = sym;
    req.last_symbol = last_flag;
    gap = in_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    model.encode_symbol(req);
    sent_count++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (model.pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(bit [15:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    model.capacity = value;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int gap;
    out_ready = 1'b0;
    forever begin
      gap = out_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      model.check_byte(out_data);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("watchdog: no request moved for %0d cycles", QUIET_LIMIT);
    $display("FAIL");
    $finish;
  end

  initial begin
    int n;
    int i;
    bit [7:0] sym;
    model = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_gaps_on = 1'b1;
    out_gaps_on = 1'b1;
    sent_count = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    write_capacity(16'hffff);
    send_symbol(8'd48, 1'b1);
    send_symbol(8'd38, 1'b1);
    send_symbol(8'd0, 1'b0);
    send_symbol(8'd255, 1'b1);
    send_symbol(8'd66, 1'b0);
    send_symbol(8'd22, 1'b1);
    send_symbol(8'd10, 1'b0);
    send_symbol(8'd13, 1'b0);
    send_symbol(8'd97, 1'b1);

    write_capacity(16'd0);
    send_symbol(8'd101, 1'b0);
    send_symbol(8'd9, 1'b1);

    write_capacity(16'd2);
    send_symbol(8'd1, 1'b0);
    send_symbol(8'd116, 1'b1);

    send_symbol(8'd97, 1'b0);
    send_symbol(8'd99, 1'b0);
    send_symbol(8'd101, 1'b0);
    write_capacity(16'd1);
    send_symbol(8'd105, 1'b1);

    write_capacity(16'hffff);
    send_symbol(8'd127, 1'b0);
    send_symbol(8'd200, 1'b1);

    while (sent_count < 220) begin
      in_gaps_on = $urandom_range(0, 3) != 0;
      out_gaps_on = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 3) == 0) begin
        write_capacity(pick_capacity());
      end
      n = $urandom_range(1, 10);
      for (i = 0; i < n; i++) begin
        if ($urandom_range(0, 29) == 0) begin
          write_capacity(pick_capacity());
        end
        if ($urandom_range(0, 9) < 6) begin
          sym = 8'($urandom_range(32, 126));
        end else begin
          sym = 8'($urandom());
        end
        send_symbol(sym, i == n - 1);
      end
    end

    drain();
    if (model.mismatch_count == 0 && model.pending_bytes.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
